### rtl/core/pet_pkg.sv
package pet_pkg;

   localparam int RATE_W     = 32;
   localparam int TIME_W     = 24;
   localparam int AGE_W      = 25;
   localparam int LOOP_W     = 16;
   localparam int SORT_W     = 21;
   localparam int SPAWN_W    = 24;
   localparam int FRAC_W     = 32;
   localparam int PROD_W     = RATE_W + TIME_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_SPAWN_RATE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIFE_TIME_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_DURATION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LOOP_COUNT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BURST_COUNT   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PARTICLES = 3'd6;

   localparam logic [1:0] MODE_INFINITE = 2'd0;
   localparam logic [1:0] MODE_ONCE     = 2'd1;
   localparam logic [1:0] MODE_MULTIPLE = 2'd2;

   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [SORT_W-1:0] SORT_CAP = 21'h10_0000;

   typedef struct packed {
      logic              done;
      logic [TIME_W-1:0] quo;
      logic              rem_nz;
   } pet_div_res_type;

endpackage

### rtl/core/pet_if.sv
interface pet_req_if;
   import pet_pkg::*;
   logic              valid;
   logic              ready;
   logic              cmd;
   logic [TIME_W-1:0] dt;
   modport source (output valid, cmd, dt, input ready);
   modport sink (input valid, cmd, dt, output ready);
endinterface

interface pet_rsp_if;
   import pet_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPAWN_W-1:0] spawn_count;
   logic [SORT_W-1:0]  sort_size;
   logic               emitter_active;
   modport source (output valid, spawn_count, sort_size, emitter_active, input ready);
   modport sink (input valid, spawn_count, sort_size, emitter_active, output ready);
endinterface

interface pet_csr_if;
   import pet_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/pet_mul.sv
module pet_mul (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pet_pkg::RATE_W-1:0]  a,
   input  logic [pet_pkg::TIME_W-1:0]  b,
   output logic [pet_pkg::PROD_W-1:0]  prod
);
   import pet_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = PROD_W'(a) * PROD_W'(b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/core/pet_div.sv
module pet_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pet_pkg::TIME_W-1:0]    num,
   input  logic [pet_pkg::TIME_W-1:0]    den,
   output pet_pkg::pet_div_res_type      res
);
   import pet_pkg::*;

   localparam int CNT_W = $clog2(TIME_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0] den_ff, den_in;
   logic [TIME_W:0]   shifted;
   logic [TIME_W+1:0] diff;

   assign shifted = {rem_ff, quo_ff[TIME_W-1]};
   assign diff    = {1'b0, shifted} - {2'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         if (!diff[TIME_W+1]) begin
            rem_in = diff[TIME_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[TIME_W-1:0];
            quo_in = {quo_ff[TIME_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(TIME_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign res.done   = done_ff;
   assign res.quo    = quo_ff;
   assign res.rem_nz = |rem_ff;

endmodule

### rtl/core/particle_emitter_tick.sv
// Per-frame controller for one particle emitter. Each request transaction is a frame tick with
// its delta time or a restart command, and gives exactly one response transaction with the
// spawn count, the sort size and the running flag. A restart, or a tick of an emitter that has
// stopped, goes straight to the finish state. A tick of a running emitter passes through the
// 24-step shift-subtract divider for the bursts per lifetime and the one-doubling-a-cycle sort
// size search above MIN_SORT_SIZE, and a single registered 32 by 24 multiplier serves all three
// products. The finish state loads the response once the response register is free, and the
// block is ready again in the same cycle as the result is loaded, even while that response
// transaction is still waiting. Configuration writes are always taken.
module particle_emitter_tick #(
   parameter int MIN_SORT_SIZE = 64
) (
   input  logic       clock,
   input  logic       reset,
   pet_req_if.sink    req_ch,
   pet_rsp_if.source  rsp_ch,
   pet_csr_if.sink    csr_ch
);
   import pet_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MUL_EST   = 4'd1;
   localparam logic [3:0] ST_EST       = 4'd2;
   localparam logic [3:0] ST_DIV       = 4'd3;
   localparam logic [3:0] ST_MUL_BURST = 4'd4;
   localparam logic [3:0] ST_SUM       = 4'd5;
   localparam logic [3:0] ST_SORT      = 4'd6;
   localparam logic [3:0] ST_LOOP      = 4'd7;
   localparam logic [3:0] ST_FINISH    = 4'd8;

   logic [RATE_W-1:0]  spawn_rate_ff, spawn_rate_in;
   logic [TIME_W-1:0]  life_time_max_ff, life_time_max_in;
   logic [TIME_W-1:0]  loop_duration_ff, loop_duration_in;
   logic [1:0]         loop_mode_ff, loop_mode_in;
   logic [LOOP_W-1:0]  loop_count_ff, loop_count_in;
   logic [LOOP_W-1:0]  burst_count_ff, burst_count_in;
   logic [SORT_W-1:0]  max_particles_ff, max_particles_in;

   logic [AGE_W-1:0]   age_ff, age_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               running_ff, running_in;
   logic               burst_pend_ff, burst_pend_in;
   logic [LOOP_W-1:0]  loops_done_ff, loops_done_in;
   logic [SORT_W-1:0]  sort_count_ff, sort_count_in;
   logic [AGE_W-1:0]   shrink_ff, shrink_in;

   logic [3:0]         state_ff, state_in;
   logic               cmd_ff, cmd_in;
   logic [TIME_W-1:0]  dt_ff, dt_in;
   logic               ran_ff, ran_in;
   logic [AGE_W-1:0]   est_ff, est_in;
   logic [TIME_W-1:0]  per_ff, per_in;
   logic [SORT_W-1:0]  cap_ff, cap_in;
   logic [SORT_W-1:0]  tgt_ff, tgt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [SPAWN_W-1:0] rsp_spawn_ff, rsp_spawn_in;
   logic [SORT_W-1:0]  rsp_sort_ff, rsp_sort_in;
   logic               rsp_active_ff, rsp_active_in;

   logic               mul_en;
   logic [RATE_W-1:0]  mul_a;
   logic [TIME_W-1:0]  mul_b;
   logic [PROD_W-1:0]  mul_prod;
   logic               div_start;
   pet_div_res_type    div_res;

   logic               use_burst;
   logic               rsp_free;
   logic [40:0]        est_sum;
   logic [AGE_W:0]     shrink_sum;
   logic [AGE_W-1:0]   shrink_sat;
   logic [AGE_W:0]     age_sum;
   logic [AGE_W-1:0]   age_sat;
   logic [AGE_W-1:0]   age_wrap;
   logic [LOOP_W-1:0]  loops_next;
   logic [PROD_W:0]    acc;
   logic [SPAWN_W+1:0] spawn_tot;
   logic [SPAWN_W-1:0] spawn_sat;

   pet_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod)
   );

   pet_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (life_time_max_ff),
      .den   (loop_duration_ff),
      .res   (div_res)
   );

   assign use_burst = (burst_count_ff != '0) && (loop_duration_ff != '0);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;

   assign est_sum    = {16'b0, est_ff} + (use_burst ? {1'b0, mul_prod[39:0]} : 41'b0);
   assign shrink_sum = {1'b0, shrink_ff} + (AGE_W + 1)'(dt_ff);
   assign shrink_sat = shrink_sum[AGE_W] ? '1 : shrink_sum[AGE_W-1:0];
   assign age_sum    = {1'b0, age_ff} + (AGE_W + 1)'(dt_ff);
   assign age_sat    = age_sum[AGE_W] ? '1 : age_sum[AGE_W-1:0];
   assign age_wrap   = age_sat - {1'b0, loop_duration_ff};
   assign loops_next = (loops_done_ff != '1) ? loops_done_ff + 1'b1 : loops_done_ff;
   assign acc        = {25'b0, frac_ff} + {1'b0, mul_prod};
   assign spawn_tot  = {1'b0, acc[PROD_W:FRAC_W]}
                       + (burst_pend_ff ? (SPAWN_W + 2)'(burst_count_ff) : '0);
   assign spawn_sat  = (spawn_tot > (SPAWN_W + 2)'({SPAWN_W{1'b1}})) ? '1
                                                                    : spawn_tot[SPAWN_W-1:0];

   always_comb begin
      spawn_rate_in    = spawn_rate_ff;
      life_time_max_in = life_time_max_ff;
      loop_duration_in = loop_duration_ff;
      loop_mode_in     = loop_mode_ff;
      loop_count_in    = loop_count_ff;
      burst_count_in   = burst_count_ff;
      max_particles_in = max_particles_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_SPAWN_RATE:    spawn_rate_in    = csr_ch.data;
            REG_LIFE_TIME_MAX: life_time_max_in = csr_ch.data[TIME_W-1:0];
            REG_LOOP_DURATION: loop_duration_in = csr_ch.data[TIME_W-1:0];
            REG_LOOP_MODE:     loop_mode_in     = csr_ch.data[1:0];
            REG_LOOP_COUNT:    loop_count_in    = csr_ch.data[LOOP_W-1:0];
            REG_BURST_COUNT:   burst_count_in   = csr_ch.data[LOOP_W-1:0];
            REG_MAX_PARTICLES: max_particles_in = csr_ch.data[SORT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      dt_in         = dt_ff;
      ran_in        = ran_ff;
      est_in        = est_ff;
      per_in        = per_ff;
      cap_in        = cap_ff;
      tgt_in        = tgt_ff;
      age_in        = age_ff;
      frac_in       = frac_ff;
      running_in    = running_ff;
      burst_pend_in = burst_pend_ff;
      loops_done_in = loops_done_ff;
      sort_count_in = sort_count_ff;
      shrink_in     = shrink_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_spawn_in  = rsp_spawn_ff;
      rsp_sort_in   = rsp_sort_ff;
      rsp_active_in = rsp_active_ff;
      mul_en        = 1'b0;
      mul_a         = spawn_rate_ff;
      mul_b         = life_time_max_ff;
      div_start     = 1'b0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               cmd_in = req_ch.cmd;
               dt_in  = req_ch.dt;
               ran_in = (req_ch.cmd == CMD_TICK) && running_ff;
               if ((req_ch.cmd == CMD_TICK) && running_ff) begin
                  state_in = ST_MUL_EST;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MUL_EST: begin
            mul_en   = 1'b1;
            state_in = ST_EST;
         end
         ST_EST: begin
            est_in    = {1'b0, mul_prod[PROD_W-1:FRAC_W]} + AGE_W'(|mul_prod[FRAC_W-1:0]);
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               per_in   = div_res.quo + TIME_W'(div_res.rem_nz);
               state_in = ST_MUL_BURST;
            end
         end
         ST_MUL_BURST: begin
            mul_en   = 1'b1;
            mul_a    = RATE_W'(burst_count_ff);
            mul_b    = per_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (est_sum > 41'(max_particles_ff)) begin
               cap_in = max_particles_ff;
            end else begin
               cap_in = est_sum[SORT_W-1:0];
            end
            tgt_in   = SORT_W'(MIN_SORT_SIZE);
            state_in = ST_SORT;
         end
         ST_SORT: begin
            if ((tgt_ff < cap_ff) && (tgt_ff < SORT_CAP)) begin
               tgt_in = {tgt_ff[SORT_W-2:0], 1'b0};
            end else begin
               if (tgt_ff > SORT_CAP) begin
                  tgt_in = SORT_CAP;
               end
               state_in = ST_LOOP;
            end
         end
         ST_LOOP: begin
            mul_en = 1'b1;
            mul_b  = dt_ff;
            if (tgt_ff >= sort_count_ff) begin
               sort_count_in = tgt_ff;
               shrink_in     = '0;
            end else if (shrink_sat > AGE_W'(life_time_max_ff)) begin
               sort_count_in = tgt_ff;
               shrink_in     = '0;
            end else begin
               shrink_in = shrink_sat;
            end
            age_in = age_sat;
            if (age_sat >= AGE_W'(loop_duration_ff)) begin
               unique case (loop_mode_ff)
                  MODE_INFINITE: begin
                     age_in        = age_wrap;
                     burst_pend_in = 1'b1;
                  end
                  MODE_ONCE: begin
                     running_in = 1'b0;
                  end
                  MODE_MULTIPLE: begin
                     age_in        = age_wrap;
                     loops_done_in = loops_next;
                     if (loops_next < loop_count_ff) begin
                        burst_pend_in = 1'b1;
                     end else begin
                        running_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_sort_in  = sort_count_ff;
               state_in     = ST_IDLE;
               if (cmd_ff == CMD_RESTART) begin
                  age_in        = '0;
                  running_in    = 1'b1;
                  loops_done_in = '0;
                  burst_pend_in = 1'b1;
                  rsp_spawn_in  = '0;
                  rsp_active_in = 1'b1;
               end else if (ran_ff) begin
                  frac_in       = acc[FRAC_W-1:0];
                  burst_pend_in = 1'b0;
                  rsp_spawn_in  = spawn_sat;
                  rsp_active_in = running_ff;
               end else begin
                  rsp_spawn_in  = '0;
                  rsp_active_in = running_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spawn_rate_ff    <= '0;
         life_time_max_ff <= 24'd65536;
         loop_duration_ff <= 24'd65536;
         loop_mode_ff     <= MODE_INFINITE;
         loop_count_ff    <= 16'd1;
         burst_count_ff   <= '0;
         max_particles_ff <= 21'd1024;
         age_ff           <= '0;
         frac_ff          <= '0;
         running_ff       <= 1'b1;
         burst_pend_ff    <= 1'b1;
         loops_done_ff    <= '0;
         sort_count_ff    <= '0;
         shrink_ff        <= '0;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         spawn_rate_ff    <= spawn_rate_in;
         life_time_max_ff <= life_time_max_in;
         loop_duration_ff <= loop_duration_in;
         loop_mode_ff     <= loop_mode_in;
         loop_count_ff    <= loop_count_in;
         burst_count_ff   <= burst_count_in;
         max_particles_ff <= max_particles_in;
         age_ff           <= age_in;
         frac_ff          <= frac_in;
         running_ff       <= running_in;
         burst_pend_ff    <= burst_pend_in;
         loops_done_ff    <= loops_done_in;
         sort_count_ff    <= sort_count_in;
         shrink_ff        <= shrink_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      dt_ff         <= dt_in;
      ran_ff        <= ran_in;
      est_ff        <= est_in;
      per_ff        <= per_in;
      cap_ff        <= cap_in;
      tgt_ff        <= tgt_in;
      rsp_spawn_ff  <= rsp_spawn_in;
      rsp_sort_ff   <= rsp_sort_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.spawn_count    = rsp_spawn_ff;
   assign rsp_ch.sort_size      = rsp_sort_ff;
   assign rsp_ch.emitter_active = rsp_active_ff;

endmodule

### rtl/core/pet_checker.sv
module pet_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [pet_pkg::SPAWN_W-1:0]  rsp_spawn_count,
   input logic [pet_pkg::SORT_W-1:0]   rsp_sort_size,
   input logic                         rsp_emitter_active
);
   import pet_pkg::*;

   // A waiting response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_spawn_count)
         && $stable(rsp_sort_size) && $stable(rsp_emitter_active))
      else $error("response changed while stalled");

   // Only one request transaction is worked on at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A new result is loaded only as the block returns to idle.
   a_result_then_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while still busy");

   a_sort_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sort_size <= SORT_CAP)
      else $error("sort size above its bound");

endmodule

bind particle_emitter_tick pet_checker u_pet_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_spawn_count    (rsp_ch.spawn_count),
   .rsp_sort_size      (rsp_ch.sort_size),
   .rsp_emitter_active (rsp_ch.emitter_active)
);
